// ===== src/vcre_pkg.sv =====
// Shared types, constants and queue entry layout for the voxel column RLE encoder.
package vcre_pkg;

   // Field widths
   localparam int VOXEL_W  = 16;
   localparam int LENGTH_W = 8;
   localparam int HEIGHT_W = 13;

   // Run and column limits
   localparam int MAX_RUN        = 255;
   localparam int HEIGHT_LIMIT   = 4096;
   localparam int HEIGHT_RESET   = 256;
   localparam int RUN_LIMIT_INT  = (MAX_RUN > 255) ? 255 : MAX_RUN;
   localparam int DEPTH_W        = (HEIGHT_LIMIT > 1) ? $clog2(HEIGHT_LIMIT) : 1;

   // Decoupling queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [VOXEL_W-1:0]  voxel_type;
   typedef logic [LENGTH_W-1:0] length_type;
   typedef logic [HEIGHT_W-1:0] height_type;
   typedef logic [DEPTH_W-1:0]  depth_type;
   typedef logic [QPTR_W-1:0]   qptr_type;
   typedef logic [QCNT_W-1:0]   qcnt_type;

   localparam voxel_type  EMPTY_VOXEL     = 16'hffff;
   localparam length_type RUN_LIMIT       = length_type'(RUN_LIMIT_INT);
   localparam height_type HEIGHT_MAX      = height_type'(HEIGHT_LIMIT);
   localparam height_type HEIGHT_DEFAULT  = height_type'(HEIGHT_RESET);
   localparam qcnt_type   QUEUE_FULL_CNT  = qcnt_type'(QUEUE_DEPTH);

   // One classified voxel: an optional closed run and an optional final run
   typedef struct packed {
      logic       close_run;
      length_type close_len;
      voxel_type  close_val;
      logic       final_run;
      length_type final_len;
      voxel_type  final_val;
      height_type first_filled;
      height_type end_filled;
   } queue_entry_type;

   // Queue status toward the back end
   typedef struct packed {
      logic            head_valid;
      queue_entry_type head;
   } queue_head_type;

endpackage

// ===== src/vcre_if.sv =====
// Channel interfaces: voxel input, run output and column height write port.
interface vcre_req_if;
   logic                valid;
   logic                ready;
   vcre_pkg::voxel_type voxel;

   modport source (output valid, output voxel, input ready);
   modport sink   (input valid, input voxel, output ready);
endinterface

interface vcre_rsp_if;
   logic                 valid;
   logic                 ready;
   vcre_pkg::length_type run_length;
   vcre_pkg::voxel_type  run_value;
   logic                 last_run;
   vcre_pkg::height_type first_filled;
   vcre_pkg::height_type end_filled;

   modport source (output valid, output run_length, output run_value, output last_run,
                   output first_filled, output end_filled, input ready);
   modport sink   (input valid, input run_length, input run_value, input last_run,
                   input first_filled, input end_filled, output ready);
endinterface

interface vcre_csr_if;
   logic                 valid;
   logic                 ready;
   vcre_pkg::height_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== src/vcre_front.sv =====
// Front end: accepts voxels, tracks the current run and column bounds, classifies results.
module vcre_front (
   input  logic                      clock,
   input  logic                      reset,
   vcre_req_if.sink                  req,
   vcre_csr_if.sink                  csr,
   input  logic                      queue_full,
   output logic                      push,
   output vcre_pkg::queue_entry_type push_entry
);

   vcre_pkg::height_type height_ff, height_in;
   vcre_pkg::voxel_type  value_ff, value_in;
   vcre_pkg::length_type count_ff, count_in;
   vcre_pkg::depth_type  depth_ff, depth_in;
   vcre_pkg::height_type lowest_ff, lowest_in;
   vcre_pkg::height_type past_ff, past_in;

   logic                 accept;
   logic                 first_voxel;
   logic                 extend_run;
   logic                 close_run;
   logic                 final_voxel;
   logic                 occupied;
   vcre_pkg::height_type depth_ext;
   vcre_pkg::height_type depth_next;
   vcre_pkg::voxel_type  run_val;
   vcre_pkg::length_type run_len;
   vcre_pkg::height_type lowest_base;
   vcre_pkg::height_type lowest_new;
   vcre_pkg::height_type past_new;

   assign csr.ready = 1'b1;
   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   // Clamp the written height to the legal range
   always_comb begin
      height_in = height_ff;
      if (csr.valid) begin
         if (csr.data == '0) begin
            height_in = vcre_pkg::height_type'(1);
         end else if (csr.data > vcre_pkg::HEIGHT_MAX) begin
            height_in = vcre_pkg::HEIGHT_MAX;
         end else begin
            height_in = csr.data;
         end
      end
   end

   // Classify the incoming voxel against the open run
   always_comb begin
      depth_ext   = {1'b0, depth_ff};
      depth_next  = depth_ext + vcre_pkg::height_type'(1);
      first_voxel = (depth_ff == '0);
      extend_run  = (req.voxel == value_ff) && (count_ff < vcre_pkg::RUN_LIMIT);
      close_run   = !first_voxel && !extend_run;
      occupied    = (req.voxel != vcre_pkg::EMPTY_VOXEL);
      final_voxel = (depth_next >= height_ff);

      if (first_voxel || close_run) begin
         run_val = req.voxel;
         run_len = vcre_pkg::length_type'(1);
      end else begin
         run_val = value_ff;
         run_len = count_ff + vcre_pkg::length_type'(1);
      end

      lowest_base = first_voxel ? height_ff : lowest_ff;
      lowest_new  = (occupied && (depth_ext < lowest_base)) ? depth_ext : lowest_base;
      past_new    = occupied ? depth_next : (first_voxel ? '0 : past_ff);
   end

   // Build the queue entry
   always_comb begin
      push                    = accept && (close_run || final_voxel);
      push_entry.close_run    = close_run;
      push_entry.close_len    = count_ff;
      push_entry.close_val    = value_ff;
      push_entry.final_run    = final_voxel;
      push_entry.final_len    = run_len;
      push_entry.final_val    = run_val;
      push_entry.first_filled = lowest_new;
      push_entry.end_filled   = past_new;
   end

   // Advance the run state, restart it at column end
   always_comb begin
      value_in  = value_ff;
      count_in  = count_ff;
      depth_in  = depth_ff;
      lowest_in = lowest_ff;
      past_in   = past_ff;
      if (accept) begin
         if (final_voxel) begin
            value_in  = '0;
            count_in  = '0;
            depth_in  = '0;
            lowest_in = height_ff;
            past_in   = '0;
         end else begin
            value_in  = run_val;
            count_in  = run_len;
            depth_in  = depth_next[vcre_pkg::DEPTH_W-1:0];
            lowest_in = lowest_new;
            past_in   = past_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= vcre_pkg::HEIGHT_DEFAULT;
         value_ff  <= '0;
         count_ff  <= '0;
         depth_ff  <= '0;
         lowest_ff <= vcre_pkg::HEIGHT_DEFAULT;
         past_ff   <= '0;
      end else begin
         height_ff <= height_in;
         value_ff  <= value_in;
         count_ff  <= count_in;
         depth_ff  <= depth_in;
         lowest_ff <= lowest_in;
         past_ff   <= past_in;
      end
   end

   // A column end always rewinds the depth
   a_final_rewinds: assert property (@(posedge clock) disable iff (reset)
      (accept && final_voxel) |=> (depth_ff == '0 && count_ff == '0))
      else $error("depth not rewound after column end");

   // The open run never outgrows the limit
   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= vcre_pkg::RUN_LIMIT)
      else $error("run count above limit");

endmodule

// ===== src/vcre_queue.sv =====
// Short queue of classified voxels between the front and back ends.
module vcre_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  vcre_pkg::queue_entry_type push_entry,
   output logic                      full,
   input  logic                      pop,
   output vcre_pkg::queue_head_type  head
);

   vcre_pkg::queue_entry_type entries_ff [vcre_pkg::QUEUE_DEPTH];
   vcre_pkg::qptr_type        wr_ff, wr_in;
   vcre_pkg::qptr_type        rd_ff, rd_in;
   vcre_pkg::qcnt_type        cnt_ff, cnt_in;

   assign full            = (cnt_ff == vcre_pkg::QUEUE_FULL_CNT);
   assign head.head_valid = (cnt_ff != '0);
   assign head.head       = entries_ff[rd_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_in  = push ? wr_ff + vcre_pkg::qptr_type'(1) : wr_ff;
      rd_in  = pop ? rd_ff + vcre_pkg::qptr_type'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + vcre_pkg::qcnt_type'(1);
      end else if (!push && pop) begin
         cnt_in = cnt_ff - vcre_pkg::qcnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.head_valid)
      else $error("pop from empty queue");

endmodule

// ===== src/vcre_back.sv =====
// Back end: expands queue entries into run blocks and holds them in the output register.
module vcre_back (
   input  logic                     clock,
   input  logic                     reset,
   input  vcre_pkg::queue_head_type head,
   output logic                     pop,
   vcre_rsp_if.source               rsp
);

   logic                 valid_ff, valid_in;
   logic                 phase_ff, phase_in;
   vcre_pkg::length_type len_ff;
   vcre_pkg::voxel_type  val_ff;
   logic                 last_ff;
   vcre_pkg::height_type first_ff;
   vcre_pkg::height_type end_ff;

   logic                 load;
   logic                 send_close;
   logic                 entry_done;

   // Pick the closed run first, then the final run
   always_comb begin
      load       = head.head_valid && (!valid_ff || rsp.ready);
      send_close = head.head.close_run && !phase_ff;
      entry_done = !send_close || !head.head.final_run;
      pop        = load && entry_done;
      phase_in   = phase_ff;
      if (load) begin
         phase_in = !entry_done;
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (load) begin
         if (send_close) begin
            len_ff   <= head.head.close_len;
            val_ff   <= head.head.close_val;
            last_ff  <= 1'b0;
            first_ff <= '0;
            end_ff   <= '0;
         end else begin
            len_ff   <= head.head.final_len;
            val_ff   <= head.head.final_val;
            last_ff  <= 1'b1;
            first_ff <= head.head.first_filled;
            end_ff   <= head.head.end_filled;
         end
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.run_length   = len_ff;
   assign rsp.run_value    = val_ff;
   assign rsp.last_run     = last_ff;
   assign rsp.first_filled = first_ff;
   assign rsp.end_filled   = end_ff;

   // Second half of an entry only exists for a closed run plus a final run
   a_phase_pair: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (head.head_valid && head.head.close_run && head.head.final_run))
      else $error("second phase without paired entry");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp.ready) |=> (valid_ff && $stable(len_ff) && $stable(last_ff)))
      else $error("output changed while stalled");

endmodule

// ===== src/voxel_column_rle_encoder.sv =====
// Top level of the voxel column run-length encoder.
// Takes 16-bit voxels on req, in increasing depth order, and emits (run_length,
// run_value) blocks on rsp; the block that ends a column carries last_run with the
// lowest occupied depth and one past the highest occupied depth. Throughput is one
// voxel per cycle while the queue is not full: the front end updates the run with
// one compare and one increment per voxel. A voxel that both closes a run and ends
// the column yields two blocks, which the back end sends one after the other; a
// four-entry queue absorbs that burst. The column height (1 to 4096, reset 256) is
// written on csr, always ready; the user must write it only while the block is
// idle, which the block does not enforce. 0 acts as 1 and larger values act as 4096.
module voxel_column_rle_encoder (
   input  logic       clock,
   input  logic       reset,
   vcre_req_if.sink   req,
   vcre_rsp_if.source rsp,
   vcre_csr_if.sink   csr
);

   logic                      queue_full;
   logic                      push;
   logic                      pop;
   vcre_pkg::queue_entry_type push_entry;
   vcre_pkg::queue_head_type  head;

   vcre_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .csr        (csr),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   vcre_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head       (head)
   );

   vcre_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the voxel column run-length encoder: directed rows, then random columns.
module testbench;

   localparam int ITEM_TARGET    = 1550;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      vcre_pkg::length_type run_length;
      vcre_pkg::voxel_type  run_value;
      logic                 last_run;
      vcre_pkg::height_type first_filled;
      vcre_pkg::height_type end_filled;
   } run_block_type;

   typedef enum logic [1:0] {ROW_HEIGHT, ROW_VOXEL, ROW_CLOSING} row_kind_type;

   // One directed row: a height write, a voxel checked by the column model,
   // or a voxel whose closing run block is typed in
   typedef struct packed {
      row_kind_type  kind;
      logic [15:0]   data;
      run_block_type closing;
   } stim_row_type;

   typedef struct packed {
      logic          typed;
      run_block_type block;
   } item_note_type;

   logic clock;
   logic reset;

   vcre_req_if req_if ();
   vcre_rsp_if rsp_if ();
   vcre_csr_if csr_if ();

   voxel_column_rle_encoder u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   // Column model state
   vcre_pkg::height_type model_height;
   vcre_pkg::voxel_type  model_value;
   vcre_pkg::length_type model_count;
   int unsigned          model_depth;
   int unsigned          model_low;
   int unsigned          model_high;

   run_block_type  fresh_runs[$];
   run_block_type  pending_runs[$];
   item_note_type  row_notes[$];
   stim_row_type   stim_rows[$];

   // Run generator state
   vcre_pkg::voxel_type gen_value;
   int unsigned         gen_left;

   bit            calm;
   int unsigned   mismatches;
   int unsigned   voxels_sent;
   int unsigned   voxels_taken;
   int unsigned   runs_checked;
   int unsigned   column_ends;
   int unsigned   capped_runs;
   int unsigned   height_writes;
   int unsigned   midcolumn_writes;
   int unsigned   quiet_cycles;
   item_note_type taken_note;
   run_block_type wanted;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic run_block_type make_block(input int unsigned len, input int unsigned val,
                                                input bit last, input int unsigned first,
                                                input int unsigned past);
      run_block_type b;
      b.run_length   = vcre_pkg::length_type'(len);
      b.run_value    = vcre_pkg::voxel_type'(val);
      b.last_run     = last;
      b.first_filled = vcre_pkg::height_type'(first);
      b.end_filled   = vcre_pkg::height_type'(past);
      return b;
   endfunction

   function automatic stim_row_type make_row(input row_kind_type kind, input int unsigned data,
                                             input run_block_type closing);
      stim_row_type r;
      r.kind    = kind;
      r.data    = data[15:0];
      r.closing = closing;
      return r;
   endfunction

   // Zero acts as one, anything past the limit acts as the limit
   function automatic int unsigned clamp_height(input vcre_pkg::height_type h);
      if (h == '0)
         return 1;
      if (h > vcre_pkg::HEIGHT_MAX)
         return vcre_pkg::HEIGHT_LIMIT;
      return 32'(h);
   endfunction

   // Advance the column model by one voxel; the blocks it causes land in fresh_runs
   function automatic void encode_voxel(input vcre_pkg::voxel_type v);
      int unsigned h;
      int unsigned z;
      h = clamp_height(model_height);
      z = model_depth;
      fresh_runs.delete();
      if (z == 0) begin
         model_low   = h;
         model_high  = 0;
         model_value = v;
         model_count = vcre_pkg::length_type'(1);
      end else if (v == model_value && model_count < vcre_pkg::RUN_LIMIT) begin
         model_count = model_count + vcre_pkg::length_type'(1);
      end else begin
         fresh_runs.push_back(make_block(model_count, model_value, 1'b0, 0, 0));
         model_value = v;
         model_count = vcre_pkg::length_type'(1);
      end
      if (v != vcre_pkg::EMPTY_VOXEL) begin
         if (z < model_low)
            model_low = z;
         model_high = z + 1;
      end
      if (z + 1 >= h) begin
         fresh_runs.push_back(make_block(model_count, model_value, 1'b1, model_low, model_high));
         model_value = '0;
         model_count = '0;
         model_depth = 0;
         model_low   = h;
         model_high  = 0;
      end else begin
         model_depth = z + 1;
      end
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t mismatch on %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   function automatic int draw_wait();
      return calm ? 0 : $urandom_range(0, 5);
   endfunction

   // Mostly runs of random length with random content, now and then a stray voxel
   function automatic vcre_pkg::voxel_type next_voxel();
      int unsigned pick;
      if (gen_left <= 8 && $urandom_range(0, 19) == 0)
         return vcre_pkg::voxel_type'($urandom);
      if (gen_left == 0) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2: gen_value = vcre_pkg::EMPTY_VOXEL;
            3: gen_value = '0;
            4: gen_value = 16'hfffe;
            5: gen_value = gen_value;
            default: gen_value = vcre_pkg::voxel_type'($urandom);
         endcase
         gen_left = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 320)
                                                  : $urandom_range(1, 6);
      end
      gen_left--;
      return gen_value;
   endfunction

   // Offer one voxel and hold it until the encoder takes it
   task automatic send_voxel(input vcre_pkg::voxel_type v, input item_note_type note);
      int gap;
      gap = draw_wait();
      row_notes.push_back(note);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.voxel <= v;
      req_if.valid <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      voxels_sent++;
   endtask

   // Drop valid, wait for every expected run block, then let the pipeline empty
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_runs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_height(input vcre_pkg::height_type h);
      if (model_depth != 0)
         midcolumn_writes++;
      csr_if.data  <= h;
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      height_writes++;
   endtask

   // Result side: hold ready low for a random stall before each transaction
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // Predict on each voxel transaction, check each run block transaction
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready)
            model_height = csr_if.data;
         if (req_if.valid && req_if.ready) begin
            taken_note = (row_notes.size() != 0) ? row_notes.pop_front() : '0;
            encode_voxel(req_if.voxel);
            if (taken_note.typed)
               pending_runs.push_back(taken_note.block);
            else
               foreach (fresh_runs[i]) pending_runs.push_back(fresh_runs[i]);
            voxels_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_runs.size() == 0) begin
               $display("%0t unexpected run block: length %0d value 0x%0h last %0b",
                        $time, rsp_if.run_length, rsp_if.run_value, rsp_if.last_run);
               mismatches++;
            end else begin
               wanted = pending_runs.pop_front();
               check_field("run_length", wanted.run_length, rsp_if.run_length);
               check_field("run_value", wanted.run_value, rsp_if.run_value);
               check_field("last_run", wanted.last_run, rsp_if.last_run);
               check_field("first_filled", wanted.first_filled, rsp_if.first_filled);
               check_field("end_filled", wanted.end_filled, rsp_if.end_filled);
               runs_checked++;
               if (wanted.last_run)
                  column_ends++;
               if (wanted.run_length == vcre_pkg::RUN_LIMIT)
                  capped_runs++;
            end
         end
         // Watchdog: end the run when no transaction moves for too long
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transaction for %0d cycles, %0d run blocks outstanding",
                     $time, quiet_cycles, pending_runs.size());
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      item_note_type        plain;
      item_note_type        typed_note;
      vcre_pkg::height_type h;
      int unsigned          pick;
      int unsigned          eff;
      int unsigned          remaining;
      int unsigned          count;
      bit                   first_phase;

      plain         = '0;
      model_height  = vcre_pkg::HEIGHT_DEFAULT;
      model_value   = '0;
      model_count   = '0;
      model_depth   = 0;
      model_low     = vcre_pkg::HEIGHT_RESET;
      model_high    = 0;
      gen_value     = '0;
      gen_left      = 0;
      calm          = 1'b0;
      mismatches    = 0;
      voxels_sent   = 0;
      voxels_taken  = 0;
      runs_checked  = 0;
      column_ends   = 0;
      capped_runs   = 0;
      height_writes = 0;
      midcolumn_writes = 0;
      quiet_cycles  = 0;

      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.voxel <= '0;
      csr_if.valid <= 1'b0;
      csr_if.data  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed rows: default height after reset, height zero and too large,
      // height changed mid-column, extreme voxel values, a closed run plus a final run
      stim_rows.push_back(make_row(ROW_VOXEL, 16'h0000, '0));
      stim_rows.push_back(make_row(ROW_HEIGHT, 1, '0));
      stim_rows.push_back(make_row(ROW_CLOSING, 16'h0000, make_block(2, 16'h0000, 1, 0, 2)));
      stim_rows.push_back(make_row(ROW_HEIGHT, 0, '0));
      stim_rows.push_back(make_row(ROW_CLOSING, 16'hffff, make_block(1, 16'hffff, 1, 1, 0)));
      stim_rows.push_back(make_row(ROW_CLOSING, 16'hfffe, make_block(1, 16'hfffe, 1, 0, 1)));
      stim_rows.push_back(make_row(ROW_HEIGHT, 3, '0));
      stim_rows.push_back(make_row(ROW_VOXEL, 16'hffff, '0));
      stim_rows.push_back(make_row(ROW_VOXEL, 16'hffff, '0));
      stim_rows.push_back(make_row(ROW_CLOSING, 16'hffff, make_block(3, 16'hffff, 1, 3, 0)));
      stim_rows.push_back(make_row(ROW_HEIGHT, 4, '0));
      stim_rows.push_back(make_row(ROW_VOXEL, 16'h0001, '0));
      stim_rows.push_back(make_row(ROW_VOXEL, 16'h8000, '0));
      stim_rows.push_back(make_row(ROW_VOXEL, 16'h8000, '0));
      stim_rows.push_back(make_row(ROW_VOXEL, 16'hffff, '0));
      stim_rows.push_back(make_row(ROW_HEIGHT, 8191, '0));
      stim_rows.push_back(make_row(ROW_VOXEL, 16'h7fff, '0));
      stim_rows.push_back(make_row(ROW_VOXEL, 16'h7fff, '0));
      stim_rows.push_back(make_row(ROW_HEIGHT, 4097, '0));
      stim_rows.push_back(make_row(ROW_VOXEL, 16'h00ff, '0));
      stim_rows.push_back(make_row(ROW_HEIGHT, 2, '0));
      stim_rows.push_back(make_row(ROW_CLOSING, 16'h00ff, make_block(2, 16'h00ff, 1, 0, 4)));
      stim_rows.push_back(make_row(ROW_HEIGHT, 4096, '0));
      stim_rows.push_back(make_row(ROW_VOXEL, 16'h5555, '0));
      stim_rows.push_back(make_row(ROW_VOXEL, 16'haaaa, '0));
      stim_rows.push_back(make_row(ROW_HEIGHT, 2, '0));
      stim_rows.push_back(make_row(ROW_VOXEL, 16'haaaa, '0));

      foreach (stim_rows[i]) begin
         case (stim_rows[i].kind)
            ROW_HEIGHT: begin
               settle();
               write_height(stim_rows[i].data[vcre_pkg::HEIGHT_W-1:0]);
            end
            ROW_CLOSING: begin
               typed_note.typed = 1'b1;
               typed_note.block = stim_rows[i].closing;
               send_voxel(stim_rows[i].data, typed_note);
            end
            default: send_voxel(stim_rows[i].data, plain);
         endcase
      end

      // Random phases: drain, write a height, then stream whole or partial columns
      first_phase = 1'b1;
      while (voxels_sent < ITEM_TARGET) begin
         settle();
         pick = $urandom_range(0, 99);
         if (first_phase)
            h = vcre_pkg::height_type'(520);
         else if (pick < 4)
            h = '0;
         else if (pick < 8)
            h = vcre_pkg::HEIGHT_MAX;
         else if (pick < 11)
            h = vcre_pkg::height_type'($urandom_range(vcre_pkg::HEIGHT_LIMIT + 1, 8191));
         else if (pick < 12)
            h = vcre_pkg::height_type'(8191);
         else if (pick < 16)
            h = vcre_pkg::height_type'($urandom_range(256, 700));
         else if (pick < 21)
            h = vcre_pkg::height_type'(1);
         else
            h = vcre_pkg::height_type'($urandom_range(2, 40));
         first_phase = 1'b0;
         calm = ($urandom_range(0, 3) == 0);
         write_height(h);
         eff = clamp_height(h);
         remaining = (model_depth < eff) ? eff - model_depth : 1;
         if (eff > 1000)
            count = $urandom_range(1, 12);
         else if ($urandom_range(0, 4) == 0)
            count = $urandom_range(1, remaining);
         else if (eff <= 100)
            count = remaining + eff * $urandom_range(0, 3);
         else
            count = remaining;
         // Stop at the item target
         if (count > ITEM_TARGET - voxels_sent)
            count = ITEM_TARGET - voxels_sent;
         repeat (count) send_voxel(next_voxel(), plain);
      end

      settle();
      $display("covered %0d voxels and %0d run blocks: %0d column ends, %0d runs at the %0d cap",
               voxels_taken, runs_checked, column_ends, capped_runs, vcre_pkg::RUN_LIMIT);
      $display("column height written %0d times, %0d of them in the middle of a column",
               height_writes, midcolumn_writes);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/vcre_pkg.sv
src/vcre_if.sv
src/vcre_front.sv
src/vcre_queue.sv
src/vcre_back.sv
src/voxel_column_rle_encoder.sv
bench/testbench.sv
